### sv/tta_pkg.sv
// Shared types, constants and codes for the triangle tangent accumulator.
// No dependencies; the divider, the top level and the bench import this package.
package tta_pkg;

    // Vertex store depth and the address width that follows from it.
    localparam int VERTEX_DEPTH = 4096;
    localparam int VIDX_W       = $clog2(VERTEX_DEPTH);

    // Port widths.
    localparam int S_TDATA_W = 200;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 160;
    localparam int M_TUSER_W = 2;
    localparam int CFG_W     = 32;

    // Datapath widths.
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int PROD_W  = 66;
    localparam int WIDE_W  = 67;
    localparam int TAN_W   = 48;
    localparam int CNT_W   = 6;

    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 32'd429;
    localparam logic [1:0] LAST_LANE = 2'd2;
    localparam logic [CNT_W-1:0] LAST_QBIT = 6'(TAN_W - 1);

    localparam logic signed [TAN_W-1:0] SAT_MAX = {1'b0, {(TAN_W-1){1'b1}}};
    localparam logic signed [TAN_W-1:0] SAT_MIN = {1'b1, {(TAN_W-1){1'b0}}};

    // Request codes.
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_TRI  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_RSVD = 2'd3;

    // Result kinds.
    localparam logic KIND_TRI = 1'b0;
    localparam logic KIND_ACC = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] v;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vrow_t;

    typedef struct packed {
        logic signed [TAN_W-1:0] z;
        logic signed [TAN_W-1:0] y;
        logic signed [TAN_W-1:0] x;
    } arow_t;

    typedef struct packed {
        logic start;
        logic neg;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHK,
        D_RUN,
        D_DONE
    } div_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_ACC,
        S_RD_OUT,
        S_VA,
        S_VB,
        S_VC,
        S_VW,
        S_DET0,
        S_DET1,
        S_DETC,
        S_ABS,
        S_CMP,
        S_AX0,
        S_AX1,
        S_AXN,
        S_DGO,
        S_DWAIT,
        S_ACR,
        S_ACW,
        S_EMIT
    } tta_state_t;

endpackage

### sv/tta_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/tta_div.sv
// Iterative restoring divider, one quotient bit per cycle, with 48-bit saturation.
// Depends on tta_pkg.
module tta_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tta_pkg::div_ctrl_t                ctrl,
    input  logic signed [tta_pkg::WIDE_W-1:0] num,
    input  logic [tta_pkg::WIDE_W-1:0]        den,
    output tta_pkg::div_stat_t                stat,
    output logic signed [tta_pkg::TAN_W-1:0]  quot
);
    import tta_pkg::*;

    div_state_t state_reg, state_next;
    logic signed [WIDE_W-1:0] num_reg;
    logic [WIDE_W-1:0] den_reg;
    logic [WIDE_W-1:0] rem_reg;
    logic [TAN_W-1:0]  shin_reg;
    logic [TAN_W-1:0]  q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic neg_reg;
    logic ovf_reg;

    logic [WIDE_W-1:0] abs_num;
    logic              ovf_now;
    logic [WIDE_W:0]   trial;
    logic              fits;

    // Magnitude of the numerator and the check for a quotient of 2^48 or more.
    assign abs_num = num_reg[WIDE_W-1] ? (WIDE_W'(0) - num_reg) : num_reg;
    assign ovf_now = {32'd0, abs_num} >= {den_reg, 32'd0};

    // One restoring step.
    assign trial = {rem_reg, shin_reg[TAN_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = D_CHK;
                end
            end
            D_CHK:
            begin
                state_next = ovf_now ? D_DONE : D_RUN;
            end
            D_RUN:
            begin
                if (cnt_reg == LAST_QBIT)
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // Status outputs.
    always_comb
    begin
        stat.busy = (state_reg != D_IDLE);
        stat.done = (state_reg == D_DONE);
    end

    // Saturated signed quotient.
    always_comb
    begin
        if (ovf_reg || q_reg[TAN_W-1])
        begin
            quot = neg_reg ? SAT_MIN : SAT_MAX;
        end
        else if (neg_reg)
        begin
            quot = TAN_W'(0) - $signed(q_reg);
        end
        else
        begin
            quot = $signed(q_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Operand and iteration registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (ctrl.start)
                begin
                    num_reg <= num;
                    den_reg <= den;
                    neg_reg <= ctrl.neg ^ num[WIDE_W-1];
                end
            end
            D_CHK:
            begin
                ovf_reg  <= ovf_now;
                rem_reg  <= WIDE_W'(abs_num[WIDE_W-1:32]);
                shin_reg <= {abs_num[31:0], 16'd0};
                q_reg    <= '0;
                cnt_reg  <= '0;
            end
            D_RUN:
            begin
                rem_reg  <= fits ? WIDE_W'(trial - {1'b0, den_reg}) : WIDE_W'(trial);
                shin_reg <= {shin_reg[TAN_W-2:0], 1'b0};
                q_reg    <= {q_reg[TAN_W-2:0], fits};
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule

### sv/triangle_tangent_accumulator.sv
// Triangle tangent accumulator: vertex and accumulator stores, shared multiplier
// and divider under one sequencer. Depends on tta_pkg, tta_ram and tta_div.
// Load: vertex row written, accumulator cleared. Read: accumulator row to output.
// Triangle: fallback edge tangent when degenerate; otherwise each of the three axes
// goes through the bit-serial divider (48 quotient bits).
// One item at a time; a finished result waits in the output register.
// rst_n clears control and sets the threshold to 429; store contents stay undefined.
module triangle_tangent_accumulator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // a[11:0], b[23:12], c[35:24], pos_x, pos_y, pos_z, tex_u, tex_v (32 each), pad
    input  logic [tta_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [tta_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // vertex_id[11:0], tangent_x[59:12], tangent_y[107:60], tangent_z[155:108], pad
    output logic [tta_pkg::M_TDATA_W-1:0] m_tdata,
    // result_kind[0], degenerate[1]
    output logic [tta_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tta_pkg::CFG_W-1:0]     cfg_data
);
    import tta_pkg::*;

    function automatic logic signed [DIFF_W-1:0] sub33(logic signed [COORD_W-1:0] p,
                                                       logic signed [COORD_W-1:0] q);
        return $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
    endfunction

    function automatic logic idx_ok(logic [11:0] i);
        return 32'(i) < VERTEX_DEPTH;
    endfunction

    function automatic logic signed [TAN_W-1:0] sat_add(logic signed [TAN_W-1:0] p,
                                                        logic signed [TAN_W-1:0] q);
        logic signed [TAN_W:0] s;
        s = $signed({p[TAN_W-1], p}) + $signed({q[TAN_W-1], q});
        if (s[TAN_W] != s[TAN_W-1])
        begin
            return s[TAN_W] ? SAT_MIN : SAT_MAX;
        end
        return s[TAN_W-1:0];
    endfunction

    tta_state_t state_reg, state_next;

    // Input fields.
    logic [1:0]  in_type;
    logic [11:0] in_a, in_b, in_c;
    vrow_t       in_row;
    logic        in_accept;

    // Request and working registers.
    logic [11:0] a_reg, b_reg, c_reg;
    logic        oor_reg;
    logic [CFG_W-1:0] thr_reg;
    vrow_t row_a_reg, row_b_reg, row_c_reg;
    logic signed [PROD_W-1:0] prod_reg, first_reg;
    logic signed [WIDE_W-1:0] det_reg, num_reg;
    logic [WIDE_W-1:0] absdet_reg;
    logic detneg_reg;
    logic deg_reg;
    logic kind_reg;
    logic [1:0] axis_reg, corner_reg;
    logic signed [TAN_W-1:0] tan_reg [3];

    // Output register.
    logic m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic out_load;

    // Memory ports.
    logic              v_we;
    logic [VIDX_W-1:0] v_raddr;
    vrow_t             v_rdata;
    logic              acc_we;
    logic [VIDX_W-1:0] acc_waddr, acc_raddr;
    arow_t             acc_wdata, acc_rdata;
    logic [11:0]       corner_idx;

    // Shared multiplier and divider.
    logic signed [DIFF_W-1:0] mul_a, mul_b;
    div_ctrl_t div_ctrl;
    div_stat_t div_stat;
    logic signed [TAN_W-1:0] div_quot;

    // Differences of the captured corners.
    logic signed [DIFF_W-1:0] d0u, d0v, d1u, d1v, e0, e1;
    logic [WIDE_W-1:0] abs_det;
    logic signed [TAN_W-1:0] fb_x, fb_y, fb_z;

    assign in_type   = s_tuser[1:0];
    assign in_a      = s_tdata[11:0];
    assign in_b      = s_tdata[23:12];
    assign in_c      = s_tdata[35:24];
    assign in_row.x  = s_tdata[67:36];
    assign in_row.y  = s_tdata[99:68];
    assign in_row.z  = s_tdata[131:100];
    assign in_row.u  = s_tdata[163:132];
    assign in_row.v  = s_tdata[195:164];
    assign in_accept = s_tvalid && s_tready;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign d0u = sub33(row_b_reg.u, row_a_reg.u);
    assign d0v = sub33(row_b_reg.v, row_a_reg.v);
    assign d1u = sub33(row_c_reg.u, row_a_reg.u);
    assign d1v = sub33(row_c_reg.v, row_a_reg.v);
    assign abs_det = det_reg[WIDE_W-1] ? (WIDE_W'(0) - det_reg) : det_reg;

    // Fallback edge tangent, B minus C, sign extended.
    assign fb_x = TAN_W'(sub33(row_b_reg.x, row_c_reg.x));
    assign fb_y = TAN_W'(sub33(row_b_reg.y, row_c_reg.y));
    assign fb_z = TAN_W'(sub33(row_b_reg.z, row_c_reg.z));

    // Edge vectors for the axis in work.
    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                e0 = sub33(row_b_reg.x, row_a_reg.x);
                e1 = sub33(row_c_reg.x, row_a_reg.x);
            end
            2'd1:
            begin
                e0 = sub33(row_b_reg.y, row_a_reg.y);
                e1 = sub33(row_c_reg.y, row_a_reg.y);
            end
            default:
            begin
                e0 = sub33(row_b_reg.z, row_a_reg.z);
                e1 = sub33(row_c_reg.z, row_a_reg.z);
            end
        endcase
    end

    // Corner whose accumulator is being updated.
    always_comb
    begin
        case (corner_reg)
            2'd0:    corner_idx = a_reg;
            2'd1:    corner_idx = b_reg;
            default: corner_idx = c_reg;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_type)
                        REQ_READ:
                        begin
                            state_next = S_RD_ACC;
                        end
                        REQ_TRI:
                        begin
                            if (idx_ok(in_a) && idx_ok(in_b) && idx_ok(in_c))
                            begin
                                state_next = S_VA;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_ACC: state_next = S_RD_OUT;
            S_RD_OUT: state_next = S_EMIT;
            S_VA:     state_next = S_VB;
            S_VB:     state_next = S_VC;
            S_VC:     state_next = S_VW;
            S_VW:     state_next = S_DET0;
            S_DET0:   state_next = S_DET1;
            S_DET1:   state_next = S_DETC;
            S_DETC:   state_next = S_ABS;
            S_ABS:    state_next = S_CMP;
            S_CMP:
            begin
                state_next = ({35'd0, thr_reg} >= absdet_reg) ? S_ACR : S_AX0;
            end
            S_AX0:    state_next = S_AX1;
            S_AX1:    state_next = S_AXN;
            S_AXN:    state_next = S_DGO;
            S_DGO:    state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = (axis_reg == LAST_LANE) ? S_ACR : S_AX0;
                end
            end
            S_ACR:    state_next = S_ACW;
            S_ACW:
            begin
                state_next = (corner_reg == LAST_LANE) ? S_EMIT : S_ACR;
            end
            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs: memory ports, multiplier operands, divider start.
    always_comb
    begin
        v_we      = in_accept && (in_type == REQ_LOAD) && idx_ok(in_a);
        acc_we    = v_we;
        acc_waddr = VIDX_W'(in_a);
        acc_wdata = '0;
        acc_raddr = VIDX_W'(a_reg);
        v_raddr   = VIDX_W'(a_reg);
        mul_a     = '0;
        mul_b     = '0;
        div_ctrl.start = 1'b0;
        div_ctrl.neg   = detneg_reg;
        out_load  = 1'b0;
        case (state_reg)
            S_VB: v_raddr = VIDX_W'(b_reg);
            S_VC: v_raddr = VIDX_W'(c_reg);
            S_DET0:
            begin
                mul_a = d0u;
                mul_b = d1v;
            end
            S_DET1:
            begin
                mul_a = d1u;
                mul_b = d0v;
            end
            S_AX0:
            begin
                mul_a = d1v;
                mul_b = e0;
            end
            S_AX1:
            begin
                mul_a = d0v;
                mul_b = e1;
            end
            S_DGO: div_ctrl.start = 1'b1;
            S_ACR: acc_raddr = VIDX_W'(corner_idx);
            S_ACW:
            begin
                acc_we      = 1'b1;
                acc_waddr   = VIDX_W'(corner_idx);
                acc_wdata.x = sat_add(acc_rdata.x, tan_reg[0]);
                acc_wdata.y = sat_add(acc_rdata.y, tan_reg[1]);
                acc_wdata.z = sat_add(acc_rdata.z, tan_reg[2]);
            end
            S_EMIT: out_load = !m_tvalid_reg || m_tready;
            default:
            begin
            end
        endcase
    end

    tta_ram #(
        .WIDTH ($bits(vrow_t)),
        .DEPTH (VERTEX_DEPTH)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (VIDX_W'(in_a)),
        .wdata (in_row),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    tta_ram #(
        .WIDTH ($bits(arow_t)),
        .DEPTH (VERTEX_DEPTH)
    ) u_accum_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    tta_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (num_reg),
        .den   (absdet_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            thr_reg      <= THRESHOLD_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Shared multiplier, registered.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Datapath registers stepped by the sequencer.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    a_reg   <= in_a;
                    b_reg   <= in_b;
                    c_reg   <= in_c;
                    oor_reg <= !idx_ok(in_a);
                end
            end
            S_RD_OUT:
            begin
                kind_reg   <= KIND_ACC;
                deg_reg    <= 1'b0;
                tan_reg[0] <= oor_reg ? '0 : acc_rdata.x;
                tan_reg[1] <= oor_reg ? '0 : acc_rdata.y;
                tan_reg[2] <= oor_reg ? '0 : acc_rdata.z;
            end
            S_VB: row_a_reg <= v_rdata;
            S_VC: row_b_reg <= v_rdata;
            S_VW: row_c_reg <= v_rdata;
            S_DET1, S_AX1: first_reg <= prod_reg;
            S_DETC:
            begin
                det_reg <= $signed({first_reg[PROD_W-1], first_reg})
                         - $signed({prod_reg[PROD_W-1], prod_reg});
            end
            S_ABS:
            begin
                absdet_reg <= abs_det;
                detneg_reg <= det_reg[WIDE_W-1];
            end
            S_CMP:
            begin
                kind_reg   <= KIND_TRI;
                axis_reg   <= '0;
                corner_reg <= '0;
                deg_reg    <= ({35'd0, thr_reg} >= absdet_reg);
                tan_reg[0] <= fb_x;
                tan_reg[1] <= fb_y;
                tan_reg[2] <= fb_z;
            end
            S_AXN:
            begin
                num_reg <= $signed({first_reg[PROD_W-1], first_reg})
                         - $signed({prod_reg[PROD_W-1], prod_reg});
            end
            S_DWAIT:
            begin
                if (div_stat.done)
                begin
                    tan_reg[axis_reg] <= div_quot;
                    axis_reg          <= axis_reg + 2'd1;
                end
            end
            S_ACW: corner_reg <= corner_reg + 2'd1;
            default:
            begin
            end
        endcase
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {4'd0, tan_reg[2], tan_reg[1], tan_reg[0], a_reg};
            m_tuser_reg <= {deg_reg, kind_reg};
        end
    end

    // The divider is only started when it has finished the previous axis.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // Accumulators are written only by a load or by the update sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        acc_we |-> (state_reg == S_ACW || state_reg == S_IDLE))
        else $error("accumulator written outside load or update");

    // A vertex read never reports the fallback tangent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && kind_reg == KIND_ACC) |-> !deg_reg)
        else $error("read result flagged degenerate");

    // No new transaction is taken while the divider still works.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_stat.busy)
        else $error("input ready while divider busy");

endmodule

### bench/triangle_tangent_accumulator_tb.sv
// Self-checking bench for the triangle tangent accumulator: drives loads, triangles and
// reads over the stream ports and checks every result against a built-in predictor.
// Depends on tta_pkg and the triangle_tangent_accumulator RTL only.
module triangle_tangent_accumulator_tb;
    import tta_pkg::*;

    localparam int RANDOM_ITEMS = 730;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int POOL_SIZE    = 40;

    typedef struct {
        logic [1:0]  req;
        logic [11:0] a;
        logic [11:0] b;
        logic [11:0] c;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] u;
        logic [31:0] v;
    } tta_item_t;

    typedef struct {
        logic        kind;
        logic [11:0] id;
        logic        deg;
        logic [47:0] tx;
        logic [47:0] ty;
        logic [47:0] tz;
    } tangent_result_t;

    // Predicts vertex store and accumulator contents and checks each result transaction.
    class tangent_scoreboard;
        int              pos_x [VERTEX_DEPTH];
        int              pos_y [VERTEX_DEPTH];
        int              pos_z [VERTEX_DEPTH];
        int              tex_u [VERTEX_DEPTH];
        int              tex_v [VERTEX_DEPTH];
        longint          acc_x [VERTEX_DEPTH];
        longint          acc_y [VERTEX_DEPTH];
        longint          acc_z [VERTEX_DEPTH];
        logic [31:0]     threshold;
        tangent_result_t expected_q[$];
        int              errors;
        int              n_tri;
        int              n_deg;
        int              n_read;
        int              n_checked;

        function new();
            threshold = THRESHOLD_RESET;
        endfunction

        // Clamp a wide signed value to the 48-bit tangent range.
        function longint clamp48(logic signed [127:0] x);
            if (x > 128'sd140737488355327)
                return 64'sd140737488355327;
            if (x < -128'sd140737488355328)
                return -64'sd140737488355328;
            return longint'(x);
        endfunction

        // One axis of the non-degenerate tangent: exact quotient truncated toward zero.
        function longint axis_tangent(longint e0, longint e1, longint dv0, longint dv1,
                                      logic signed [127:0] det);
            logic signed [127:0] num;
            logic [127:0]        mag_num;
            logic [127:0]        mag_det;
            logic [127:0]        quo;
            logic signed [127:0] signed_quo;
            num = 128'(dv1) * 128'(e0) - 128'(dv0) * 128'(e1);
            mag_num = num < 0 ? -num : num;
            mag_det = det < 0 ? -det : det;
            quo = (mag_num << 16) / mag_det;
            signed_quo = ((num < 0) != (det < 0)) ? -$signed(quo) : $signed(quo);
            return clamp48(signed_quo);
        endfunction

        function void add_tangent(int idx, longint tx, longint ty, longint tz);
            acc_x[idx] = clamp48(128'(acc_x[idx]) + 128'(tx));
            acc_y[idx] = clamp48(128'(acc_y[idx]) + 128'(ty));
            acc_z[idx] = clamp48(128'(acc_z[idx]) + 128'(tz));
        endfunction

        // Apply one accepted input transaction and queue the result it causes.
        function void note_item(logic [S_TUSER_W-1:0] user, logic [S_TDATA_W-1:0] data);
            int                  a;
            int                  b;
            int                  c;
            longint              du0;
            longint              dv0;
            longint              du1;
            longint              dv1;
            logic signed [127:0] det;
            logic [127:0]        mag_det;
            longint              tx;
            longint              ty;
            longint              tz;
            tangent_result_t     res;
            a = int'(data[11:0]);
            b = int'(data[23:12]);
            c = int'(data[35:24]);
            case (user)
                REQ_LOAD:
                begin
                    pos_x[a] = data[67:36];
                    pos_y[a] = data[99:68];
                    pos_z[a] = data[131:100];
                    tex_u[a] = data[163:132];
                    tex_v[a] = data[195:164];
                    acc_x[a] = 0;
                    acc_y[a] = 0;
                    acc_z[a] = 0;
                end
                REQ_READ:
                begin
                    res = '{KIND_ACC, a[11:0], 1'b0, acc_x[a][47:0], acc_y[a][47:0],
                            acc_z[a][47:0]};
                    expected_q.push_back(res);
                    n_read++;
                end
                REQ_TRI:
                begin
                    du0 = longint'(tex_u[b]) - longint'(tex_u[a]);
                    dv0 = longint'(tex_v[b]) - longint'(tex_v[a]);
                    du1 = longint'(tex_u[c]) - longint'(tex_u[a]);
                    dv1 = longint'(tex_v[c]) - longint'(tex_v[a]);
                    det = 128'(du0) * 128'(dv1) - 128'(du1) * 128'(dv0);
                    mag_det = det < 0 ? -det : det;
                    res.deg = (mag_det <= {96'd0, threshold});
                    if (res.deg)
                    begin
                        tx = longint'(pos_x[b]) - longint'(pos_x[c]);
                        ty = longint'(pos_y[b]) - longint'(pos_y[c]);
                        tz = longint'(pos_z[b]) - longint'(pos_z[c]);
                        n_deg++;
                    end
                    else
                    begin
                        tx = axis_tangent(longint'(pos_x[b]) - pos_x[a],
                                          longint'(pos_x[c]) - pos_x[a], dv0, dv1, det);
                        ty = axis_tangent(longint'(pos_y[b]) - pos_y[a],
                                          longint'(pos_y[c]) - pos_y[a], dv0, dv1, det);
                        tz = axis_tangent(longint'(pos_z[b]) - pos_z[a],
                                          longint'(pos_z[c]) - pos_z[a], dv0, dv1, det);
                    end
                    add_tangent(a, tx, ty, tz);
                    add_tangent(b, tx, ty, tz);
                    add_tangent(c, tx, ty, tz);
                    res.kind = KIND_TRI;
                    res.id   = a[11:0];
                    res.tx   = tx[47:0];
                    res.ty   = ty[47:0];
                    res.tz   = tz[47:0];
                    expected_q.push_back(res);
                    n_tri++;
                end
                default:
                begin
                    // Unused request code: no effect.
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [47:0] got, logic [47:0] want);
            $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
                     n_checked);
            errors++;
        endtask

        // Compare one accepted result transaction with the oldest expectation.
        task check_result(logic [M_TUSER_W-1:0] user, logic [M_TDATA_W-1:0] data);
            tangent_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", 48'(data[11:0]), 48'd0);
                return;
            end
            want = expected_q.pop_front();
            if (user[0] !== want.kind)
                report_mismatch("result_kind", 48'(user[0]), 48'(want.kind));
            if (data[11:0] !== want.id)
                report_mismatch("vertex_id", 48'(data[11:0]), 48'(want.id));
            if (user[1] !== want.deg)
                report_mismatch("degenerate", 48'(user[1]), 48'(want.deg));
            if (data[59:12] !== want.tx)
                report_mismatch("tangent_x", data[59:12], want.tx);
            if (data[107:60] !== want.ty)
                report_mismatch("tangent_y", data[107:60], want.ty);
            if (data[155:108] !== want.tz)
                report_mismatch("tangent_z", data[155:108], want.tz);
            n_checked++;
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;

    tangent_scoreboard sb = new();

    int          cycle_count;
    int          burst_left;
    int          stall_mode;
    int          stall_count;
    logic [11:0] vertex_pool [POOL_SIZE];
    bit          vertex_loaded [VERTEX_DEPTH];
    logic [31:0] last_u;
    logic [31:0] last_v;

    triangle_tangent_accumulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock with a period of two time units.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Note every accepted input and configuration transaction in the predictor.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_item(s_tuser, s_tdata);
        if (rst_n && cfg_valid && cfg_ready)
            sb.threshold = cfg_data;
    end

    // Result side: a randomly redrawn stall pattern drives m_tready; results are checked on accept.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
        stall_count <= stall_count + 1;
        if (stall_count % 64 == 63)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_count % 16 == 0);
        endcase
    end

    function automatic logic [S_TDATA_W-1:0] pack_item(tta_item_t it);
        return {4'd0, it.v, it.u, it.pz, it.py, it.px, it.c, it.b, it.a};
    endfunction

    // Send one item; valid stays high within a burst, and a gap follows each burst.
    task automatic send_item(tta_item_t it);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_item(it);
        s_tuser  <= it.req;
        do
            @(posedge clk);
        while (!s_tready);
        if (it.req == REQ_LOAD)
            vertex_loaded[it.a] = 1'b1;
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // Wait for all results, let any load still in flight finish, then write the threshold.
    task automatic write_threshold(logic [31:0] value);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Coordinate values: full range, moderate, near zero, or an extreme.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2, 3:    return 32'($signed($urandom_range(0, 2097152)) - 1048576);
            4:       return 32'($signed($urandom_range(0, 262144)) - 131072);
            default:
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
        endcase
    endfunction

    function automatic logic [11:0] pick_loaded();
        logic [11:0] idx;
        do
            idx = vertex_pool[$urandom_range(0, POOL_SIZE - 1)];
        while (!vertex_loaded[idx]);
        return idx;
    endfunction

    // Mostly loads, triangles and reads over a pool of vertices, with some noise.
    function automatic tta_item_t random_item();
        tta_item_t it;
        int        sel;
        it = '{REQ_LOAD, 12'd0, 12'd0, 12'd0, $urandom, $urandom, $urandom, $urandom,
               $urandom};
        it.b = 12'($urandom);
        it.c = 12'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 30)
        begin
            it.req = REQ_LOAD;
            it.a   = vertex_pool[$urandom_range(0, POOL_SIZE - 1)];
            it.px  = pick_coord();
            it.py  = pick_coord();
            it.pz  = pick_coord();
            // Now and then reuse the last texture coordinate to make flat UV triangles.
            if ($urandom_range(0, 4) == 0)
            begin
                it.u = last_u;
                it.v = last_v;
            end
            else
            begin
                it.u = pick_coord();
                it.v = pick_coord();
            end
            last_u = it.u;
            last_v = it.v;
        end
        else if (sel < 75)
        begin
            it.req = REQ_TRI;
            it.a   = pick_loaded();
            it.b   = pick_loaded();
            it.c   = pick_loaded();
            if ($urandom_range(0, 7) == 0)
                it.c = it.a;
        end
        else if (sel < 96)
        begin
            it.req = REQ_READ;
            it.a   = pick_loaded();
        end
        else
        begin
            it.req = REQ_RSVD;
            it.a   = 12'($urandom);
        end
        return it;
    endfunction

    function automatic tta_item_t load_item(logic [11:0] idx, logic [31:0] px,
                                            logic [31:0] py, logic [31:0] pz,
                                            logic [31:0] u, logic [31:0] v);
        return '{REQ_LOAD, idx, 12'd0, 12'd0, px, py, pz, u, v};
    endfunction

    function automatic tta_item_t op_item(logic [1:0] req, logic [11:0] a, logic [11:0] b,
                                          logic [11:0] c);
        return '{req, a, b, c, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    endfunction

    // Main sequence.
    initial
    begin
        logic [31:0] thresholds [5];
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        cycle_count = 0;
        stall_mode  = 0;
        stall_count = 0;
        burst_left  = 4;
        last_u      = 32'd0;
        last_v      = 32'd0;
        vertex_pool[0] = 12'd0;
        vertex_pool[1] = 12'd4095;
        for (int i = 2; i < POOL_SIZE; i++)
            vertex_pool[i] = 12'($urandom_range(1, 4094));
        vertex_pool[2] = 12'd1;
        vertex_pool[3] = 12'd2;
        vertex_pool[4] = 12'hAAA;
        vertex_pool[5] = 12'h555;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the threshold still at its reset value.
        send_item(load_item(12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0));
        send_item(load_item(12'd4095, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h0001_0000, 32'd0));
        send_item(load_item(12'd1, 32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd0,
                            32'h0001_0000));
        // Unit UV triangle with extreme positions, followed by reads of its three corners.
        send_item(op_item(REQ_TRI, 12'd0, 12'd4095, 12'd1));
        send_item(op_item(REQ_READ, 12'd0, 12'd0, 12'd0));
        send_item(op_item(REQ_READ, 12'd4095, 12'd0, 12'd0));
        send_item(op_item(REQ_READ, 12'd1, 12'd0, 12'd0));
        // Same UV as vertex 0: zero determinant falls back to the edge tangent.
        send_item(load_item(12'd2, 32'h1234_5678, 32'hFEDC_BA98, 32'h0000_0001, 32'd0,
                            32'd0));
        send_item(op_item(REQ_TRI, 12'd0, 12'd2, 12'd1));
        // Repeated corners receive the tangent more than once.
        send_item(op_item(REQ_TRI, 12'd0, 12'd0, 12'd4095));
        send_item(op_item(REQ_TRI, 12'd4095, 12'd4095, 12'd4095));
        send_item(op_item(REQ_READ, 12'd0, 12'd0, 12'd0));
        // Extreme texture coordinates give a large determinant.
        send_item(load_item(12'hAAA, $urandom, $urandom, $urandom, 32'h8000_0000,
                            32'h7FFF_FFFF));
        send_item(load_item(12'h555, $urandom, $urandom, $urandom, 32'h7FFF_FFFF,
                            32'h8000_0000));
        send_item(op_item(REQ_TRI, 12'hAAA, 12'h555, 12'd1));
        send_item(op_item(REQ_TRI, 12'h555, 12'hAAA, 12'd0));
        send_item(op_item(REQ_READ, 12'h555, 12'd0, 12'd0));
        // Unused request code is ignored.
        send_item('{REQ_RSVD, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        // Reloading a vertex clears its accumulator.
        send_item(load_item(12'd0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'd0,
                            32'd0));
        send_item(op_item(REQ_READ, 12'd0, 12'd0, 12'd0));
        send_item(op_item(REQ_READ, 12'd2, 12'd0, 12'd0));

        // Random part over several thresholds, extremes included.
        thresholds[0] = 32'd0;
        thresholds[1] = 32'hFFFF_FFFF;
        thresholds[2] = $urandom;
        thresholds[3] = $urandom_range(0, 65535);
        thresholds[4] = 32'd429;
        for (int p = 0; p < 5; p++)
        begin
            s_tvalid <= 1'b0;
            write_threshold(thresholds[p]);
            for (int i = 0; i < RANDOM_ITEMS / 5; i++)
                send_item(random_item());
        end
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Checked %0d results: %0d triangles (%0d degenerate) and %0d reads.",
                 sb.n_checked, sb.n_tri, sb.n_deg, sb.n_read);
        $display("Thresholds covered zero, all ones, reset value and random settings.");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
